### hdl/sfr_pkg.sv
package sfr_pkg;

    localparam int MAX_RECORDS_DEF = 16;
    localparam int REC_W           = 24;

    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_OWN    = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_HEADER = 3'd1,
        ST_WRONG_ADDR = 3'd2,
        ST_CHECKSUM   = 3'd3,
        ST_TOO_LONG   = 3'd4
    } sfr_status_t;

    typedef struct packed {
        logic        vld;
        sfr_status_t status;
        logic [7:0]  src;
        logic [7:0]  cmd;
    } sfr_job_t;

endpackage

### hdl/sfr_rec_mem.sv
module sfr_rec_mem import sfr_pkg::*; #(
    parameter int DEPTH = MAX_RECORDS_DEF,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [REC_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [REC_W-1:0] rd_data
);

    logic [REC_W-1:0] mem [DEPTH];
    logic [REC_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/sfr_parser.sv
module sfr_parser import sfr_pkg::*; #(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [7:0]                           cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_byte,
    input  logic                                 s_start,
    input  logic                                 emit_busy,
    input  logic                                 job_take,
    output sfr_job_t                             job,
    output logic [$clog2(MAX_RECORDS+1)-1:0]     job_nrec,
    output logic                                 wr_en,
    output logic [((MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1)-1:0] wr_addr,
    output logic [REC_W-1:0]                     wr_data
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam logic [7:0] LEN_LIMIT = 8'(3 * MAX_RECORDS);
    localparam logic [CNT_W-1:0] HELD_MAX = CNT_W'(MAX_RECORDS);

    typedef enum logic [2:0] {
        P_IDLE, P_DEST, P_SRC, P_CMD, P_LEN, P_DATA, P_CHECK
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [7:0]        header_reg, header_next;
    logic [7:0]        own_reg, own_next;
    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        left_reg, left_next;
    logic [7:0]        src_reg, src_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [1:0]        bir_reg, bir_next;
    logic [15:0]       part_reg, part_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    sfr_job_t          job_reg, job_next;
    logic [CNT_W-1:0]  nrec_reg, nrec_next;
    logic              accept;

    assign s_tready = !job_reg.vld && !emit_busy;
    assign accept   = s_tvalid && s_tready;
    assign job      = job_reg;
    assign job_nrec = nrec_reg;
    assign wr_addr  = held_reg[IDX_W-1:0];
    assign wr_data  = {part_reg, s_byte};

    always_comb begin
        phase_next  = phase_reg;
        header_next = header_reg;
        own_next    = own_reg;
        sum_next    = sum_reg;
        left_next   = left_reg;
        src_next    = src_reg;
        cmd_next    = cmd_reg;
        bir_next    = bir_reg;
        part_next   = part_reg;
        held_next   = held_reg;
        job_next    = job_reg;
        nrec_next   = nrec_reg;
        wr_en       = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                REG_HEADER: header_next = cfg_wdata;
                REG_OWN:    own_next    = cfg_wdata;
                default:    ;
            endcase
        end

        if (job_take) begin
            job_next.vld = 1'b0;
        end

        if (accept) begin
            if (s_start) begin
                sum_next  = 8'd0;
                left_next = 8'd0;
                bir_next  = 2'd0;
                part_next = 16'd0;
                held_next = '0;
                src_next  = 8'd0;
                cmd_next  = 8'd0;
                if (s_byte != header_reg) begin
                    phase_next = P_IDLE;
                    job_next   = '{vld: 1'b1, status: ST_BAD_HEADER, src: 8'd0, cmd: 8'd0};
                    nrec_next  = '0;
                end else begin
                    sum_next   = s_byte;
                    phase_next = P_DEST;
                end
            end else begin
                case (phase_reg)
                    P_DEST: begin
                        if (s_byte != own_reg) begin
                            phase_next = P_IDLE;
                            job_next   = '{vld: 1'b1, status: ST_WRONG_ADDR,
                                           src: 8'd0, cmd: 8'd0};
                            nrec_next  = '0;
                        end else begin
                            sum_next   = sum_reg + s_byte;
                            phase_next = P_SRC;
                        end
                    end
                    P_SRC: begin
                        src_next   = s_byte;
                        sum_next   = sum_reg + s_byte;
                        phase_next = P_CMD;
                    end
                    P_CMD: begin
                        cmd_next   = s_byte;
                        sum_next   = sum_reg + s_byte;
                        phase_next = P_LEN;
                    end
                    P_LEN: begin
                        if (s_byte > LEN_LIMIT) begin
                            phase_next = P_IDLE;
                            job_next   = '{vld: 1'b1, status: ST_TOO_LONG,
                                           src: 8'd0, cmd: 8'd0};
                            nrec_next  = '0;
                        end else begin
                            sum_next   = sum_reg + s_byte;
                            left_next  = s_byte;
                            phase_next = (s_byte == 8'd0) ? P_CHECK : P_DATA;
                        end
                    end
                    P_DATA: begin
                        sum_next = sum_reg + s_byte;
                        if (bir_reg < 2'd2) begin
                            part_next = {part_reg[7:0], s_byte};
                            bir_next  = bir_reg + 2'd1;
                        end else begin
                            if (held_reg < HELD_MAX) begin
                                wr_en     = 1'b1;
                                held_next = held_reg + CNT_W'(1);
                            end
                            bir_next  = 2'd0;
                            part_next = 16'd0;
                        end
                        left_next = left_reg - 8'd1;
                        if (left_reg == 8'd1) begin
                            phase_next = P_CHECK;
                        end
                    end
                    P_CHECK: begin
                        phase_next = P_IDLE;
                        if (s_byte != sum_reg) begin
                            job_next  = '{vld: 1'b1, status: ST_CHECKSUM,
                                          src: 8'd0, cmd: 8'd0};
                            nrec_next = '0;
                        end else begin
                            job_next  = '{vld: 1'b1, status: ST_OK,
                                          src: src_reg, cmd: cmd_reg};
                            nrec_next = held_reg;
                        end
                    end
                    default: phase_next = P_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= P_IDLE;
            header_reg <= 8'hAA;
            own_reg    <= 8'h00;
            sum_reg    <= 8'd0;
            left_reg   <= 8'd0;
            src_reg    <= 8'd0;
            cmd_reg    <= 8'd0;
            bir_reg    <= 2'd0;
            part_reg   <= 16'd0;
            held_reg   <= '0;
            job_reg    <= '0;
            nrec_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            own_reg    <= own_next;
            sum_reg    <= sum_next;
            left_reg   <= left_next;
            src_reg    <= src_next;
            cmd_reg    <= cmd_next;
            bir_reg    <= bir_next;
            part_reg   <= part_next;
            held_reg   <= held_next;
            job_reg    <= job_next;
            nrec_reg   <= nrec_next;
        end
    end

`ifndef SYNTHESIS
    a_data_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == P_DATA |-> left_reg != 8'd0)
        else $error("data phase with no bytes left");

    a_write_on_record_end: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (phase_reg == P_DATA && bir_reg == 2'd2 && accept))
        else $error("record write outside a record's last byte");

    a_job_from_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(job_reg.vld) |-> $past(accept))
        else $error("job raised without an input transfer");
`endif

endmodule

### hdl/sfr_emitter.sv
module sfr_emitter import sfr_pkg::*; #(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sfr_job_t                             job,
    input  logic [$clog2(MAX_RECORDS+1)-1:0]     job_nrec,
    output logic                                 job_take,
    output logic                                 emit_busy,
    output logic                                 rd_en,
    output logic [((MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1)-1:0] rd_addr,
    input  logic [REC_W-1:0]                     rd_data,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((40 + $clog2(MAX_RECORDS+1)
                   + ((MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [2:0]                           m_tuser,
    output logic                                 m_tlast
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int RAW_W = 40 + CNT_W + IDX_W;
    localparam int TD_W  = ((RAW_W + 7) / 8) * 8;

    typedef enum logic [1:0] {E_IDLE, E_FETCH, E_SEND} emit_state_t;

    emit_state_t       state_reg;
    logic [CNT_W-1:0]  nrec_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              valid_reg;
    logic              last_reg;
    sfr_status_t       status_reg;
    logic [7:0]        src_reg;
    logic [7:0]        cmd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [REC_W-1:0]  rec_reg;
    logic              fetch_last;
    logic              send_last;
    logic              send_adv;

    assign job_take   = job.vld && state_reg == E_IDLE;
    assign emit_busy  = (state_reg == E_FETCH) || (state_reg == E_SEND && !last_reg);
    assign fetch_last = (CNT_W'(idx_reg) + CNT_W'(1)) == nrec_reg;
    assign send_last  = (CNT_W'(idx_reg) + CNT_W'(2)) == nrec_reg;
    assign send_adv   = state_reg == E_SEND && m_tready && !last_reg;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_reg + IDX_W'(1);
        case (state_reg)
            E_IDLE: begin
                rd_addr = '0;
                rd_en   = job_take && job.status == ST_OK && job_nrec != '0;
            end
            E_FETCH: begin
                rd_en = !fetch_last;
            end
            E_SEND: begin
                rd_addr = idx_reg + IDX_W'(2);
                rd_en   = send_adv && !send_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= E_IDLE;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
            nrec_reg   <= '0;
            idx_reg    <= '0;
            status_reg <= ST_OK;
            src_reg    <= 8'd0;
            cmd_reg    <= 8'd0;
            cnt_reg    <= '0;
            rec_reg    <= '0;
        end else begin
            case (state_reg)
                E_IDLE: begin
                    if (job_take) begin
                        status_reg <= job.status;
                        src_reg    <= job.src;
                        cmd_reg    <= job.cmd;
                        nrec_reg   <= job_nrec;
                        idx_reg    <= '0;
                        if (job.status != ST_OK || job_nrec == '0) begin
                            cnt_reg   <= '0;
                            rec_reg   <= '0;
                            last_reg  <= 1'b1;
                            valid_reg <= 1'b1;
                            state_reg <= E_SEND;
                        end else begin
                            cnt_reg   <= job_nrec;
                            state_reg <= E_FETCH;
                        end
                    end
                end
                E_FETCH: begin
                    rec_reg   <= rd_data;
                    last_reg  <= fetch_last;
                    valid_reg <= 1'b1;
                    state_reg <= E_SEND;
                end
                E_SEND: begin
                    if (m_tready) begin
                        if (last_reg) begin
                            valid_reg <= 1'b0;
                            last_reg  <= 1'b0;
                            state_reg <= E_IDLE;
                        end else begin
                            rec_reg  <= rd_data;
                            idx_reg  <= idx_reg + IDX_W'(1);
                            last_reg <= send_last;
                        end
                    end
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = TD_W'({rec_reg[7:0], rec_reg[15:8], rec_reg[23:16],
                             (cnt_reg == '0) ? IDX_W'(0) : idx_reg,
                             cnt_reg, cmd_reg, src_reg});

`ifndef SYNTHESIS
    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status_reg != ST_OK) |->
            (m_tlast && src_reg == 8'd0 && cmd_reg == 8'd0 && cnt_reg == '0
             && rec_reg == '0))
        else $error("error result carries frame data or is not last");

    a_last_at_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast && status_reg == ST_OK && cnt_reg != '0) |->
            (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg)
        else $error("last record index does not match count");

    a_fetch_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == E_FETCH |-> $past(rd_en))
        else $error("fetch without a memory read");
`endif

endmodule

### hdl/sensor_frame_receiver_unit.sv
// From the byte that causes it, an error result passes the job and output registers; from
// its checksum byte, a good frame's first record passes the job register, the memory read
// register and output registers. Throughput: one byte per cycle; records then leave one per
// cycle while m_tready is high, from the record memory's registered read port, and input is
// held off until the final result is loaded. Reset: synchronous, active low; clears the
// parser, emitter and registers to 0xAA/0x00. The record memory is not cleared.
module sensor_frame_receiver_unit import sfr_pkg::*; #(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    // source_address, command, record_count, record_index, device_id, value_high,
    // value_low, zero fill
    output logic [((40 + $clog2(MAX_RECORDS+1)
                   + ((MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

    sfr_job_t          job;
    logic [CNT_W-1:0]  job_nrec;
    logic              job_take;
    logic              emit_busy;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [REC_W-1:0]  wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [REC_W-1:0]  rd_data;

    sfr_parser #(.MAX_RECORDS(MAX_RECORDS)) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_byte    (s_tdata),
        .s_start   (s_tuser),
        .emit_busy (emit_busy),
        .job_take  (job_take),
        .job       (job),
        .job_nrec  (job_nrec),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    sfr_rec_mem #(.DEPTH(MAX_RECORDS), .AW(IDX_W)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sfr_emitter #(.MAX_RECORDS(MAX_RECORDS)) u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job       (job),
        .job_nrec  (job_nrec),
        .job_take  (job_take),
        .emit_busy (emit_busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### tb/sv/tb_sensor_frame_receiver_unit.sv
module tb_sensor_frame_receiver_unit;
    import sfr_pkg::*;

    localparam int CNT_W   = $clog2(MAX_RECORDS_DEF + 1);
    localparam int IDX_W   = (MAX_RECORDS_DEF > 1) ? $clog2(MAX_RECORDS_DEF) : 1;
    localparam int TDATA_W = ((40 + CNT_W + IDX_W + 7) / 8) * 8;
    localparam int SRC_LSB = 0;
    localparam int CMD_LSB = 8;
    localparam int CNT_LSB = 16;
    localparam int IDX_LSB = CNT_LSB + CNT_W;
    localparam int DEV_LSB = IDX_LSB + IDX_W;
    localparam int VH_LSB  = DEV_LSB + 8;
    localparam int VL_LSB  = VH_LSB + 8;
    localparam int MAX_LEN = 3 * MAX_RECORDS_DEF;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [2:0] {
        RX_IDLE,
        RX_DEST,
        RX_SRC,
        RX_CMD,
        RX_LEN,
        RX_DATA,
        RX_CHECK
    } rx_phase_t;

    typedef struct {
        sfr_status_t      status;
        logic [7:0]       src;
        logic [7:0]       cmd;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] idx;
        logic [7:0]       dev;
        logic [7:0]       val_hi;
        logic [7:0]       val_lo;
        logic             is_last;
    } frame_result_t;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = 1'b0;
    logic [7:0]         cfg_wdata = 8'h00;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = 8'h00;
    logic               s_tuser   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [2:0]         m_tuser;
    logic               m_tlast;

    sensor_frame_receiver_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    frame_result_t    expected_records[$];
    int               fails = 0;
    int               idle_pct = 0;
    int               stall_pct = 0;
    int               hold_cycles = 0;
    int               frame_bytes = 0;
    int               results_due = 0;

    logic [7:0]       hdr_cfg = 8'hAA;
    logic [7:0]       addr_cfg = 8'h00;
    rx_phase_t        rx_phase = RX_IDLE;
    logic [7:0]       bytes_left = '0;
    logic [7:0]       run_sum = '0;
    logic [7:0]       fr_src = '0;
    logic [7:0]       fr_cmd = '0;
    logic [7:0]       fr_len = '0;
    logic [1:0]       rec_byte = '0;
    logic [15:0]      rec_partial = '0;
    logic [CNT_W-1:0] rec_held = '0;
    logic [23:0]      rec_mem[MAX_RECORDS_DEF];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic push_result(input sfr_status_t st, input logic [7:0] src, cmd,
                               input logic [CNT_W-1:0] cnt, input logic [IDX_W-1:0] idx,
                               input logic [23:0] rec, input logic lst);
        frame_result_t r;
        r.status  = st;
        r.src     = src;
        r.cmd     = cmd;
        r.count   = cnt;
        r.idx     = idx;
        r.dev     = rec[23:16];
        r.val_hi  = rec[15:8];
        r.val_lo  = rec[7:0];
        r.is_last = lst;
        expected_records.push_back(r);
        results_due++;
    endtask

    task automatic frame_error(input sfr_status_t st);
        rx_phase = RX_IDLE;
        push_result(st, 8'h00, 8'h00, '0, '0, 24'h0, 1'b1);
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic start);
        logic [CNT_W-1:0] cnt;
        if (start) begin
            run_sum     = '0;
            bytes_left  = '0;
            rec_byte    = '0;
            rec_partial = '0;
            rec_held    = '0;
            fr_src      = '0;
            fr_cmd      = '0;
            fr_len      = '0;
            if (b != hdr_cfg) begin
                frame_error(ST_BAD_HEADER);
            end else begin
                run_sum  = b;
                rx_phase = RX_DEST;
            end
            return;
        end
        case (rx_phase)
            RX_DEST: begin
                if (b != addr_cfg) begin
                    frame_error(ST_WRONG_ADDR);
                end else begin
                    run_sum += b;
                    rx_phase = RX_SRC;
                end
            end
            RX_SRC: begin
                fr_src   = b;
                run_sum += b;
                rx_phase = RX_CMD;
            end
            RX_CMD: begin
                fr_cmd   = b;
                run_sum += b;
                rx_phase = RX_LEN;
            end
            RX_LEN: begin
                if (b > MAX_LEN) begin
                    frame_error(ST_TOO_LONG);
                end else begin
                    run_sum   += b;
                    fr_len     = b;
                    bytes_left = b;
                    rx_phase   = (b == 0) ? RX_CHECK : RX_DATA;
                end
            end
            RX_DATA: begin
                run_sum += b;
                if (rec_byte < 2) begin
                    rec_partial = {rec_partial[7:0], b};
                    rec_byte++;
                end else begin
                    if (rec_held < MAX_RECORDS_DEF) begin
                        rec_mem[rec_held] = {rec_partial, b};
                        rec_held++;
                    end
                    rec_byte    = '0;
                    rec_partial = '0;
                end
                bytes_left--;
                if (bytes_left == 0) rx_phase = RX_CHECK;
            end
            RX_CHECK: begin
                if (b != run_sum) begin
                    frame_error(ST_CHECKSUM);
                end else begin
                    rx_phase = RX_IDLE;
                    cnt = CNT_W'(fr_len / 3);
                    if (cnt == 0 || rec_held == 0) begin
                        push_result(ST_OK, fr_src, fr_cmd, '0, '0, 24'h0, 1'b1);
                    end else begin
                        for (int i = 0; i < rec_held; i++)
                            push_result(ST_OK, fr_src, fr_cmd, cnt, IDX_W'(i), rec_mem[i],
                                        i + 1 == rec_held);
                    end
                end
            end
            default: rx_phase = RX_IDLE;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    task automatic check_result();
        frame_result_t want;
        if (expected_records.size() == 0) begin
            $error("result transfer with nothing expected: status %0h", m_tuser);
            fails++;
            return;
        end
        want = expected_records.pop_front();
        check_field("status", want.status, m_tuser);
        check_field("source_address", want.src, m_tdata[SRC_LSB +: 8]);
        check_field("command", want.cmd, m_tdata[CMD_LSB +: 8]);
        check_field("record_count", want.count, m_tdata[CNT_LSB +: CNT_W]);
        check_field("record_index", want.idx, m_tdata[IDX_LSB +: IDX_W]);
        check_field("device_id", want.dev, m_tdata[DEV_LSB +: 8]);
        check_field("value_high", want.val_hi, m_tdata[VH_LSB +: 8]);
        check_field("value_low", want.val_lo, m_tdata[VL_LSB +: 8]);
        check_field("last", want.is_last, m_tlast);
    endtask

    // check each result transfer, then pick the next ready value
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result();
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        deframe_byte(b, start);
    endtask

    task automatic send_frame(input logic [7:0] hdr, dst, src, cmd, len,
                              input int ndata, input int fill, input int sum_err,
                              input int cut);
        logic [7:0] fb[$];
        logic [7:0] csum;
        int n;
        fb = {hdr, dst, src, cmd, len};
        for (int i = 0; i < ndata; i++) fb.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        csum = '0;
        foreach (fb[i]) csum += fb[i];
        fb.push_back(csum + 8'(sum_err));
        n = (cut < 0) ? fb.size() : cut;
        for (int i = 0; i < n; i++) send_byte(fb[i], i == 0);
        frame_bytes += n;
    endtask

    task automatic good_frame(input logic [7:0] len, input int fill);
        send_frame(hdr_cfg, addr_cfg, 8'($urandom), 8'($urandom), len, len, fill, 0, -1);
    endtask

    // hold input low and let the block finish before touching registers
    task automatic drain();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (expected_records.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_HEADER) hdr_cfg = v;
        else addr_cfg = v;
        @(posedge aclk);
    endtask

    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_frame(8'hAA, 8'h00, 8'h00, 8'h00, 8'd0, 0, -1, 0, -1);
        send_frame(8'hAA, 8'h00, 8'hFF, 8'hFF, 8'd1, 1, 8'hFF, 0, -1);
        send_frame(8'hAA, 8'h00, 8'h5A, 8'hA5, 8'd5, 5, -1, 0, -1);
        send_frame(8'hAA, 8'h00, 8'h01, 8'h02, 8'd49, 3, -1, 0, -1);
        send_frame(8'hAA, 8'h00, 8'h01, 8'h02, 8'd255, 2, -1, 0, -1);
        send_frame(8'h55, 8'h00, 8'h01, 8'h02, 8'd3, 3, -1, 0, -1);
        send_frame(8'hAA, 8'hFF, 8'h01, 8'h02, 8'd3, 3, -1, 0, -1);
        send_frame(8'hAA, 8'h00, 8'h01, 8'h02, 8'd6, 6, -1, 1, -1);
        send_frame(8'hAA, 8'h00, 8'h01, 8'h02, 8'd0, 0, -1, 8'h80, -1);
        send_frame(8'hAA, 8'h00, 8'h77, 8'h66, 8'd9, 9, -1, 0, 8);
        send_frame(8'hAA, 8'h00, 8'h44, 8'h33, 8'd6, 6, -1, 0, -1);
        send_frame(8'hAA, 8'h00, 8'h44, 8'h33, 8'd6, 6, -1, 0, 1);
        send_frame(8'hAA, 8'h00, 8'h22, 8'h11, 8'd3, 3, -1, 0, -1);
        send_byte(8'h00, 1'b0);
        drain();
    endtask

    task automatic test_registers();
        write_reg(REG_HEADER, 8'h00);
        write_reg(REG_OWN, 8'hFF);
        good_frame(8'd3, 8'h00);
        send_frame(8'hFF, 8'hFF, 8'h01, 8'h02, 8'd3, 3, -1, 0, -1);
        send_frame(8'h00, 8'h00, 8'h01, 8'h02, 8'd3, 3, -1, 0, -1);
        drain();
        write_reg(REG_HEADER, 8'hFF);
        write_reg(REG_OWN, 8'h00);
        good_frame(8'd6, 8'hFF);
        send_frame(8'hAA, 8'h00, 8'h01, 8'h02, 8'd3, 3, -1, 0, -1);
        send_frame(8'hFF, 8'h80, 8'h01, 8'h02, 8'd3, 3, -1, 0, -1);
        drain();
    endtask

    task automatic random_frame();
        int kind, len, nd, cut, sum_err;
        logic [7:0] hdr, dst;
        kind    = $urandom_range(99);
        hdr     = hdr_cfg;
        dst     = addr_cfg;
        len     = ($urandom_range(9) == 0) ? $urandom_range(13, MAX_LEN) : $urandom_range(0, 12);
        nd      = len;
        cut     = -1;
        sum_err = 0;
        if (kind < 70) begin
        end else if (kind < 78) begin
            sum_err = $urandom_range(1, 255);
        end else if (kind < 84) begin
            dst ^= 8'($urandom_range(1, 255));
        end else if (kind < 89) begin
            hdr ^= 8'($urandom_range(1, 255));
        end else if (kind < 93) begin
            len = $urandom_range(MAX_LEN + 1, 255);
            nd  = $urandom_range(0, 6);
        end else if (kind < 97) begin
            cut = $urandom_range(1, len + 5);
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
            return;
        end
        send_frame(hdr, dst, 8'($urandom), 8'($urandom), 8'(len), nd, -1, sum_err, cut);
    endtask

    task automatic test_random(input int idle, input int stall);
        int bytes0, results0;
        idle_pct  = idle;
        stall_pct = stall;
        write_reg(REG_HEADER, 8'($urandom));
        write_reg(REG_OWN, 8'($urandom));
        bytes0   = frame_bytes;
        results0 = results_due;
        while (frame_bytes - bytes0 < 8 || results_due - results0 < 2) random_frame();
        good_frame(8'($urandom_range(0, 6)), -1);
        drain();
    endtask

    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_cycles = 300;
        good_frame(8'd48, -1);
        good_frame(8'd3, -1);
        drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_registers();
        test_random(0, 0);
        test_random(59, 0);
        test_random(0, 59);
        test_random(22, 22);
        test_backpressure();
        if (expected_records.size() != 0) begin
            $error("%0d expected results never arrived", expected_records.size());
            fails++;
        end
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sensor_frame_receiver_unit.f
hdl/sfr_pkg.sv
hdl/sfr_rec_mem.sv
hdl/sfr_parser.sv
hdl/sfr_emitter.sv
hdl/sensor_frame_receiver_unit.sv
tb/sv/tb_sensor_frame_receiver_unit.sv
